// ===== rtl/solenoid_pulse_train_sequencer_macros.svh =====
// Assertion helpers shared by the sequencer modules.
// Each expects clk_i and rst_ni in the enclosing module.
`ifndef SOLENOID_PULSE_TRAIN_SEQUENCER_MACROS_SVH
`define SOLENOID_PULSE_TRAIN_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SPTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPTS_ASSERT_IMP(lbl, ante, cons, msg)
`define SPTS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/spts_pkg.sv =====
package spts_pkg;

  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_DEPTH_MAX = 16;
  localparam int MAX_PULSES      = 10;

  localparam int FILL_W     = $clog2(QUEUE_DEPTH_MAX + 1);
  localparam int OFF_W      = $clog2(QUEUE_DEPTH_MAX);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [9:0]  FULL_DUTY    = 10'd1023;
  localparam logic [6:0]  PERCENT_MAX  = 7'd100;
  // floor(x / 100) == (x * 5243) >> 19 for every x = p * 1023 with p up to 100
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_PULSE = 3'd0,
    CFG_LATER_PULSE = 3'd1,
    CFG_GAP         = 3'd2,
    CFG_BOOST       = 3'd3,
    CFG_HOLD_DUTY   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_BOOST = 4'b0010,
    PH_HOLD  = 4'b0100,
    PH_GAP   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0]  first_pulse_ms;
    logic [7:0]  later_pulse_ms;
    logic [11:0] gap_ms;
    logic [7:0]  boost_len_ms;
    logic [6:0]  hold_duty_percent;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    first_pulse_ms:    8'd30,
    later_pulse_ms:    8'd30,
    gap_ms:            12'd150,
    boost_len_ms:      8'd10,
    hold_duty_percent: 7'd50
  };

  typedef struct packed {
    op_e        operation;
    logic [3:0] pulse_count;
  } item_t;

  typedef struct packed {
    logic [9:0] drive_duty;
    logic       train_active;
    logic       request_dropped;
    logic [2:0] waiting_trains;
  } result_t;

  typedef struct packed {
    logic              push;
    logic [3:0]        push_len;
    logic [FILL_W-1:0] pop_cnt;
  } qcmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [3:0]        head_len;
    logic              multi_found;
    logic [OFF_W-1:0]  multi_off;
    logic [3:0]        multi_len;
  } qstat_t;

  // Saturate at 100 %, then scale to full duty with a reciprocal multiply.
  function automatic logic [9:0] hold_duty(input logic [6:0] pct);
    logic [6:0]  p;
    logic [16:0] scaled;
    logic [29:0] prod;
    p      = (pct > PERCENT_MAX) ? PERCENT_MAX : pct;
    scaled = {p, 10'b0} - 17'(p);
    prod   = 30'(scaled) * 30'(DIV100_RECIP);
    return prod[DIV100_SHIFT +: 10];
  endfunction

endpackage

// ===== rtl/spts_if.sv =====
interface spts_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [3:0] pulse_count;

  modport source (output valid, output operation, output pulse_count, input ready);
  modport sink   (input valid, input operation, input pulse_count, output ready);
endinterface

interface spts_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] drive_duty;
  logic       train_active;
  logic       request_dropped;
  logic [2:0] waiting_trains;

  modport source (output valid, output drive_duty, output train_active,
                  output request_dropped, output waiting_trains, input ready);
  modport sink   (input valid, input drive_duty, input train_active,
                  input request_dropped, input waiting_trains, output ready);
endinterface

interface spts_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [spts_pkg::CFG_IDX_W-1:0]     index;
  logic [spts_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/spts_queue.sv =====
`include "solenoid_pulse_train_sequencer_macros.svh"

module spts_queue #(
  parameter int QueueDepth = spts_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spts_pkg::qcmd_t  cmd_i,
  output spts_pkg::qstat_t status_o
);

  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int FW = spts_pkg::FILL_W;
  localparam int OW = spts_pkg::OFF_W;

  logic [3:0]    mem_q [QueueDepth];
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] wr_addr;

  // Sum of a ring index and a value no larger than the depth, folded back into the ring.
  function automatic logic [AW-1:0] wrap(input logic [FW:0] sum);
    logic [FW:0] s;
    s = sum;
    if (s >= (FW+1)'(QueueDepth)) begin
      s = s - (FW+1)'(QueueDepth);
    end
    return AW'(s);
  endfunction

  assign wr_addr = wrap((FW+1)'(head_q) + (FW+1)'(fill_q));
  assign head_d  = wrap((FW+1)'(head_q) + (FW+1)'(cmd_i.pop_cnt));
  assign fill_d  = fill_q + FW'(cmd_i.push) - cmd_i.pop_cnt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wr_addr] <= cmd_i.push_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // Find the oldest waiting request of more than one pulse.
  always_comb begin
    logic [AW-1:0] pos;
    status_o.fill        = fill_q;
    status_o.head_len    = mem_q[head_q];
    status_o.multi_found = 1'b0;
    status_o.multi_off   = '0;
    status_o.multi_len   = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      pos = wrap((FW+1)'(head_q) + (FW+1)'(i));
      if (!status_o.multi_found && (FW'(i) < fill_q) && (mem_q[pos] > 4'd1)) begin
        status_o.multi_found = 1'b1;
        status_o.multi_off   = OW'(i);
        status_o.multi_len   = mem_q[pos];
      end
    end
  end

  `SPTS_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FW'(QueueDepth), "queue fill beyond depth")
  `SPTS_ASSERT_IMP(a_push_room, cmd_i.push, fill_q < FW'(QueueDepth), "push into full queue")
  `SPTS_ASSERT_IMP(a_pop_avail, cmd_i.pop_cnt != '0, !cmd_i.push && (cmd_i.pop_cnt <= fill_q),
                   "pop beyond fill or with push")

endmodule

// ===== rtl/spts_core.sv =====
`include "solenoid_pulse_train_sequencer_macros.svh"

module spts_core #(
  parameter int QueueDepth = spts_pkg::QUEUE_DEPTH,
  parameter int MaxPulses  = spts_pkg::MAX_PULSES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  spts_pkg::item_t   item_i,
  input  spts_pkg::cfg_t    cfg_i,
  input  spts_pkg::qstat_t  qstat_i,
  output spts_pkg::qcmd_t   qcmd_o,
  output spts_pkg::result_t result_o
);

  localparam int FW = spts_pkg::FILL_W;

  typedef struct packed {
    spts_pkg::phase_e ph;
    logic [11:0]      rem;
    logic [3:0]       idx;
    logic [3:0]       len;
  } seq_t;

  localparam seq_t SEQ_IDLE = '{ph: spts_pkg::PH_IDLE, rem: '0, idx: '0, len: '0};

  seq_t seq_q, seq_d;

  logic       b, h1, hl, g, e1, emult;
  logic [3:0] req_len;
  logic       need_end, need_next, dropped;
  logic [3:0] nxt_idx;
  logic [FW-1:0] fill_next;

  assign b     = cfg_i.boost_len_ms != '0;
  assign h1    = (cfg_i.first_pulse_ms != '0) && (cfg_i.hold_duty_percent != '0);
  assign hl    = (cfg_i.later_pulse_ms != '0) && (cfg_i.hold_duty_percent != '0);
  assign g     = cfg_i.gap_ms != '0;
  // e1: a one-pulse train has no phase; emult: no train has any phase
  assign e1    = !b && !h1;
  assign emult = e1 && !g && !hl;

  assign req_len = (item_i.pulse_count == 4'd0)         ? 4'd1 :
                   (item_i.pulse_count > 4'(MaxPulses)) ? 4'(MaxPulses) :
                   item_i.pulse_count;

  // Enter the first non-empty phase of a train of n pulses.
  function automatic seq_t start_train(input logic [3:0] n, input spts_pkg::cfg_t c);
    seq_t s;
    logic sb, sh1, shl, sg;
    sb  = c.boost_len_ms != '0;
    sh1 = (c.first_pulse_ms != '0) && (c.hold_duty_percent != '0);
    shl = (c.later_pulse_ms != '0) && (c.hold_duty_percent != '0);
    sg  = c.gap_ms != '0;
    priority if (sb) begin
      s = '{ph: spts_pkg::PH_BOOST, rem: 12'(c.boost_len_ms), idx: 4'd0, len: n};
    end else if (sh1) begin
      s = '{ph: spts_pkg::PH_HOLD, rem: 12'(c.first_pulse_ms), idx: 4'd0, len: n};
    end else if ((n > 4'd1) && sg) begin
      s = '{ph: spts_pkg::PH_GAP, rem: c.gap_ms, idx: 4'd1, len: n};
    end else if ((n > 4'd1) && shl) begin
      s = '{ph: spts_pkg::PH_HOLD, rem: 12'(c.later_pulse_ms), idx: 4'd1, len: n};
    end else begin
      s = SEQ_IDLE;
    end
    return s;
  endfunction

  always_comb begin
    seq_d            = seq_q;
    qcmd_o.push      = 1'b0;
    qcmd_o.push_len  = req_len;
    qcmd_o.pop_cnt   = '0;
    dropped          = 1'b0;
    need_end         = 1'b0;
    need_next        = 1'b0;
    nxt_idx          = seq_q.idx + 4'd1;

    if (step_i) begin
      if (item_i.operation == spts_pkg::OP_TICK) begin
        if (seq_q.ph != spts_pkg::PH_IDLE) begin
          seq_d.rem = (seq_q.rem != '0) ? seq_q.rem - 12'd1 : seq_q.rem;
          if (seq_d.rem == '0) begin
            unique case (seq_q.ph)
              spts_pkg::PH_BOOST: begin
                if ((seq_q.idx == 4'd0) ? h1 : hl) begin
                  seq_d.ph  = spts_pkg::PH_HOLD;
                  seq_d.rem = (seq_q.idx == 4'd0) ? 12'(cfg_i.first_pulse_ms)
                                                  : 12'(cfg_i.later_pulse_ms);
                end else begin
                  need_end = 1'b1;
                end
              end
              spts_pkg::PH_HOLD: begin
                need_end = 1'b1;
              end
              spts_pkg::PH_GAP: begin
                priority if (b) begin
                  seq_d.ph  = spts_pkg::PH_BOOST;
                  seq_d.rem = 12'(cfg_i.boost_len_ms);
                end else if ((seq_q.idx == 4'd0) ? h1 : hl) begin
                  seq_d.ph  = spts_pkg::PH_HOLD;
                  seq_d.rem = (seq_q.idx == 4'd0) ? 12'(cfg_i.first_pulse_ms)
                                                  : 12'(cfg_i.later_pulse_ms);
                end else begin
                  need_end = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end else begin
        if (seq_q.ph == spts_pkg::PH_IDLE) begin
          seq_d = start_train(req_len, cfg_i);
        end else if (qstat_i.fill < FW'(QueueDepth)) begin
          qcmd_o.push = 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end

      // End of a pulse: with no gap, every later pulse of an all-empty kind collapses
      if (need_end) begin
        if (nxt_idx < seq_q.len) begin
          priority if (g) begin
            seq_d = '{ph: spts_pkg::PH_GAP, rem: cfg_i.gap_ms, idx: nxt_idx, len: seq_q.len};
          end else if (b) begin
            seq_d = '{ph: spts_pkg::PH_BOOST, rem: 12'(cfg_i.boost_len_ms), idx: nxt_idx,
                      len: seq_q.len};
          end else if (hl) begin
            seq_d = '{ph: spts_pkg::PH_HOLD, rem: 12'(cfg_i.later_pulse_ms), idx: nxt_idx,
                      len: seq_q.len};
          end else begin
            need_next = 1'b1;
          end
        end else begin
          need_next = 1'b1;
        end
      end

      // Train done: drop empty waiting trains and start the first one with a phase
      if (need_next) begin
        seq_d = SEQ_IDLE;
        priority if (!e1) begin
          if (qstat_i.fill != '0) begin
            qcmd_o.pop_cnt = FW'(1);
            seq_d          = start_train(qstat_i.head_len, cfg_i);
          end
        end else if (!emult && qstat_i.multi_found) begin
          qcmd_o.pop_cnt = FW'(qstat_i.multi_off) + FW'(1);
          seq_d          = start_train(qstat_i.multi_len, cfg_i);
        end else begin
          qcmd_o.pop_cnt = qstat_i.fill;
        end
      end
    end
  end

  assign fill_next = qstat_i.fill + FW'(qcmd_o.push) - qcmd_o.pop_cnt;

  always_comb begin
    unique case (seq_d.ph)
      spts_pkg::PH_BOOST: result_o.drive_duty = spts_pkg::FULL_DUTY;
      spts_pkg::PH_HOLD:  result_o.drive_duty = spts_pkg::hold_duty(cfg_i.hold_duty_percent);
      default:            result_o.drive_duty = '0;
    endcase
    result_o.train_active    = seq_d.ph != spts_pkg::PH_IDLE;
    result_o.request_dropped = dropped;
    result_o.waiting_trains  = 3'(fill_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_IDLE;
    end else if (step_i) begin
      seq_q <= seq_d;
    end
  end

  `SPTS_ASSERT_IMP(a_rem_live, seq_q.ph != spts_pkg::PH_IDLE, seq_q.rem != '0,
                   "running phase with nothing left")
  `SPTS_ASSERT_IMP(a_idle_empty, seq_q.ph == spts_pkg::PH_IDLE, qstat_i.fill == '0,
                   "requests waiting while idle")
  `SPTS_ASSERT_IMP(a_idx_range, seq_q.ph != spts_pkg::PH_IDLE, seq_q.idx < seq_q.len,
                   "pulse index beyond train length")

endmodule

// ===== rtl/solenoid_pulse_train_sequencer.sv =====
// Solenoid pulse-train sequencer. Each input item is a one-millisecond tick or a
// pulse-train request, and gives exactly one result; a new item is taken every
// cycle while the result register is free or being drained, so one item per
// cycle is sustained. Every item passes an input register, one step of the
// phase/queue update, then the result register. Requests arriving while a
// train runs wait in a QueueDepth-entry queue and are refused with
// request_dropped when it is full. Configuration writes are always taken at
// once and are meant for when no request is in flight.
module solenoid_pulse_train_sequencer #(
  parameter int QueueDepth = spts_pkg::QUEUE_DEPTH,
  parameter int MaxPulses  = spts_pkg::MAX_PULSES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spts_cfg_if.sink    cfg_i,
  spts_in_if.sink     in_i,
  spts_out_if.source  out_o
);

  spts_pkg::cfg_t    cfg_q;
  spts_pkg::item_t   item_q;
  spts_pkg::result_t result_d, result_q;
  spts_pkg::qcmd_t   qcmd;
  spts_pkg::qstat_t  qstat;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              step;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= spts_pkg::CFG_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        spts_pkg::CFG_FIRST_PULSE: cfg_q.first_pulse_ms    <= cfg_i.data[7:0];
        spts_pkg::CFG_LATER_PULSE: cfg_q.later_pulse_ms    <= cfg_i.data[7:0];
        spts_pkg::CFG_GAP:         cfg_q.gap_ms            <= cfg_i.data;
        spts_pkg::CFG_BOOST:       cfg_q.boost_len_ms      <= cfg_i.data[7:0];
        spts_pkg::CFG_HOLD_DUTY:   cfg_q.hold_duty_percent <= cfg_i.data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Advance when an item is held and the result slot is free or draining
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.operation   <= spts_pkg::op_e'(in_i.operation);
      item_q.pulse_count <= in_i.pulse_count;
    end
  end

  spts_core #(
    .QueueDepth (QueueDepth),
    .MaxPulses  (MaxPulses)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .qstat_i  (qstat),
    .qcmd_o   (qcmd),
    .result_o (result_d)
  );

  spts_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (qcmd),
    .status_o (qstat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.drive_duty      = result_q.drive_duty;
  assign out_o.train_active    = result_q.train_active;
  assign out_o.request_dropped = result_q.request_dropped;
  assign out_o.waiting_trains  = result_q.waiting_trains;

endmodule
